// ----- sv/spd_pkg.sv -----
// shared types, codes and helpers for the snap packet deframer
`default_nettype none

package spd_pkg;

    localparam int SPD_BYTE_W  = 8;
    localparam int SPD_POS_W   = 11;
    localparam int SPD_KIND_W  = 3;
    localparam int SPD_TDATA_W = 40;
    localparam int SPD_TUSER_W = 2;

    // result queue between the classifier and the output stage
    localparam int SPD_QUEUE_DEPTH = 4;
    localparam int SPD_QPTR_W      = 2;

    // byte roles
    localparam logic [2:0] KIND_OUTSIDE = 3'd0;
    localparam logic [2:0] KIND_SYNC    = 3'd1;
    localparam logic [2:0] KIND_HEADER  = 3'd2;
    localparam logic [2:0] KIND_DEST    = 3'd3;
    localparam logic [2:0] KIND_SOURCE  = 3'd4;
    localparam logic [2:0] KIND_FLAGS   = 3'd5;
    localparam logic [2:0] KIND_DATA    = 3'd6;
    localparam logic [2:0] KIND_CHECK   = 3'd7;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERRUN  = 2'd1;
    localparam logic [1:0] ERR_FRAMING  = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    localparam logic [1:0] CHK_NONE     = 2'd0;
    localparam logic [1:0] CHK_MATCH    = 2'd1;
    localparam logic [1:0] CHK_MISMATCH = 2'd2;

    localparam logic [1:0] CFG_SYNC_VALUE   = 2'd0;
    localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd1;
    localparam logic [1:0] CFG_CHECK_ENABLE = 2'd2;

    localparam logic [2:0] EDM_SUM8 = 3'd2;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [10:0] position;
        logic [2:0]  byte_kind;
        logic        packet_last;
        logic [10:0] data_count;
        logic [2:0]  edm_mode;
        logic [1:0]  ack_bits;
        logic [1:0]  check_status;
        logic [1:0]  error_code;
    } spd_result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spd_qstat_t;

    // data counts 9 to 15 stand for 8 << (n & 7)
    function automatic logic [10:0] expand_count(input logic [3:0] n);
        logic [10:0] r;
        if (n <= 4'd8)
            r = 11'(n);
        else
            r = 11'(8) << n[2:0];
        return r;
    endfunction

    function automatic logic [2:0] check_bytes(input logic [2:0] mode);
        logic [2:0] r;
        case (mode)
            3'd2, 3'd3: r = 3'd1;
            3'd4:       r = 3'd2;
            3'd5:       r = 3'd4;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/spd_front.sv -----
// classifier: packet state, header decode, byte roles and sum check
`default_nettype none

module spd_front #(
    parameter int COUNT_WIDTH = 11
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [10:0]          cfg_data,
    input  wire logic                 accept,
    input  wire logic [7:0]           rx_value,
    input  wire logic                 overrun_flag,
    input  wire logic                 framing_flag,
    output spd_pkg::spd_result_t      res
);
    import spd_pkg::*;

    localparam int SW = ((COUNT_WIDTH > SPD_POS_W) ? COUNT_WIDTH : SPD_POS_W) + 1;
    localparam logic PHASE_WAIT   = 1'b0;
    localparam logic PHASE_PACKET = 1'b1;

    logic [7:0]             sync_value_reg;
    logic [10:0]            length_limit_reg;
    logic                   check_enable_reg;

    logic                   phase_reg,    phase_next;
    logic [COUNT_WIDTH-1:0] count_reg,    count_next;
    logic [10:0]            exp_len_reg,  exp_len_next;
    logic [7:0]             first_hdr_reg, first_hdr_next;
    logic [2:0]             mode_reg,     mode_next;
    logic [10:0]            data_len_reg, data_len_next;
    logic [7:0]             sum_reg,      sum_next;

    logic                   start;
    logic                   in_pkt;
    logic                   too_long;
    logic [COUNT_WIDTH-1:0] pos;
    logic [SW-1:0]          pos_w;
    logic [SW-1:0]          pos_inc;
    logic [10:0]            d_end, s_end, f_end, n_end;
    logic [2:0]             kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg   <= 8'd84;
            length_limit_reg <= 11'd2047;
            check_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_VALUE:   sync_value_reg   <= cfg_data[7:0];
                CFG_LENGTH_LIMIT: length_limit_reg <= cfg_data;
                CFG_CHECK_ENABLE: check_enable_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        exp_len_next   = exp_len_reg;
        first_hdr_next = first_hdr_reg;
        mode_next      = mode_reg;
        data_len_next  = data_len_reg;
        sum_next       = sum_reg;

        start    = (phase_reg == PHASE_WAIT) && (rx_value == sync_value_reg);
        pos      = start ? '0 : count_reg;
        pos_w    = SW'(pos);
        pos_inc  = pos_w + SW'(1);
        too_long = (pos_inc > SW'(length_limit_reg)) || (pos == '1);
        in_pkt   = 1'b0;
        kind     = KIND_OUTSIDE;

        d_end = 11'(3) + 11'(first_hdr_reg[7:6]);
        s_end = d_end + 11'(first_hdr_reg[5:4]);
        f_end = s_end + 11'(first_hdr_reg[3:2]);
        n_end = f_end + data_len_reg;

        res              = '0;
        res.byte_out     = rx_value;

        if (overrun_flag || framing_flag)
        begin
            res.error_code = overrun_flag ? ERR_OVERRUN : ERR_FRAMING;
            phase_next     = PHASE_WAIT;
        end
        else if ((phase_reg == PHASE_PACKET) || start)
        begin
            if (too_long)
            begin
                res.error_code = ERR_TOO_LONG;
                phase_next     = PHASE_WAIT;
            end
            else if (start)
            begin
                phase_next     = PHASE_PACKET;
                count_next     = COUNT_WIDTH'(1);
                exp_len_next   = '0;
                first_hdr_next = '0;
                mode_next      = '0;
                data_len_next  = '0;
                sum_next       = '0;
                kind           = KIND_SYNC;
                in_pkt         = 1'b1;
            end
            else
            begin
                in_pkt = 1'b1;
                if (pos_w == SW'(1))
                begin
                    first_hdr_next = rx_value;
                    kind           = KIND_HEADER;
                end
                else if (pos_w == SW'(2))
                begin
                    mode_next     = rx_value[6:4];
                    data_len_next = expand_count(rx_value[3:0]);
                    exp_len_next  = 11'(3) + 11'(first_hdr_reg[7:6])
                                  + 11'(first_hdr_reg[5:4]) + 11'(first_hdr_reg[3:2])
                                  + data_len_next + 11'(check_bytes(rx_value[6:4]));
                    kind          = KIND_HEADER;
                end
                else if (pos_w < SW'(d_end))
                    kind = KIND_DEST;
                else if (pos_w < SW'(s_end))
                    kind = KIND_SOURCE;
                else if (pos_w < SW'(f_end))
                    kind = KIND_FLAGS;
                else if (pos_w < SW'(n_end))
                    kind = KIND_DATA;
                else
                    kind = KIND_CHECK;

                if (kind == KIND_CHECK)
                begin
                    if ((mode_reg == EDM_SUM8) && check_enable_reg)
                        res.check_status = (sum_reg == rx_value) ? CHK_MATCH : CHK_MISMATCH;
                end
                else
                    sum_next = sum_reg + rx_value;

                count_next = pos_inc[COUNT_WIDTH-1:0];
                if ((pos_w >= SW'(2)) && (pos_inc >= SW'(exp_len_next)))
                begin
                    res.packet_last = 1'b1;
                    phase_next      = PHASE_WAIT;
                end
            end
        end

        res.byte_kind = kind;
        if (in_pkt)
        begin
            res.position   = SPD_POS_W'(pos);
            res.data_count = data_len_next;
            res.edm_mode   = mode_next;
            res.ack_bits   = first_hdr_next[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_WAIT;
            count_reg     <= '0;
            exp_len_reg   <= '0;
            first_hdr_reg <= '0;
            mode_reg      <= '0;
            data_len_reg  <= '0;
            sum_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            exp_len_reg   <= exp_len_next;
            first_hdr_reg <= first_hdr_next;
            mode_reg      <= mode_next;
            data_len_reg  <= data_len_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/spd_queue.sv -----
// short result queue between classifier and output stage
`default_nettype none

module spd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire spd_pkg::spd_result_t push_data,
    input  wire logic                 pop,
    output spd_pkg::spd_result_t      pop_data,
    output spd_pkg::spd_qstat_t       stat
);
    import spd_pkg::*;

    spd_result_t             mem_reg [SPD_QUEUE_DEPTH];
    logic [SPD_QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [SPD_QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [SPD_QPTR_W:0]     count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + SPD_QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + SPD_QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (SPD_QPTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (SPD_QPTR_W+1)'(1);
    end

    assign stat.full  = (count_reg == (SPD_QPTR_W+1)'(SPD_QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/spd_back.sv -----
// output stage: registered result, packed onto the master stream
`default_nettype none

module spd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spd_pkg::spd_result_t          q_data,
    input  wire spd_pkg::spd_qstat_t           q_stat,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [spd_pkg::SPD_TDATA_W-1:0]    m_tdata,
    output logic [spd_pkg::SPD_KIND_W-1:0]     m_tuser,
    output logic                               m_tlast
);
    import spd_pkg::*;

    logic         valid_reg;
    spd_result_t  item_reg;

    assign pop = !q_stat.empty && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || m_tready)
            valid_reg <= !q_stat.empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= q_data;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, item_reg.error_code, item_reg.check_status, item_reg.ack_bits,
                       item_reg.edm_mode, item_reg.data_count, item_reg.position,
                       item_reg.byte_out};
    assign m_tuser  = item_reg.byte_kind;
    assign m_tlast  = item_reg.packet_last;

endmodule

`default_nettype wire

// ----- sv/snap_packet_deframer_core.sv -----
// snap packet deframer top level: classifier, result queue and output stage
// an accepted item passes through the result queue and the output register before it shows on m_tvalid
// throughput: one byte per cycle while the result queue is not full; the four-entry queue rides out output stalls
// s_tready drops only while the result queue is full
// reset (rst_n low, asynchronous): waiting for sync, counters and header fields zero,
// registers back to sync 84, limit 2047, check on, queue and output stage empty
`default_nettype none

module snap_packet_deframer_core #(
    parameter int COUNT_WIDTH = 11
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [10:0]                   cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // rx_value
    input  wire logic [spd_pkg::SPD_TUSER_W-1:0] s_tuser, // overrun_flag, framing_flag
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // byte_out, position, data_count, edm_mode, ack_bits, check_status, error_code, pad
    output logic [spd_pkg::SPD_TDATA_W-1:0]    m_tdata,
    output logic [spd_pkg::SPD_KIND_W-1:0]     m_tuser,   // byte_kind
    output logic                               m_tlast
);
    import spd_pkg::*;

    spd_result_t  front_res;
    spd_result_t  q_data;
    spd_qstat_t   q_stat;
    logic         accept;
    logic         pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;

    spd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .rx_value     (s_tdata),
        .overrun_flag (s_tuser[0]),
        .framing_flag (s_tuser[1]),
        .res          (front_res)
    );

    spd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_res),
        .pop       (pop),
        .pop_data  (q_data),
        .stat      (q_stat)
    );

    spd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    // a completed packet ends on a clean byte past the sync
    a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[38:37] == ERR_NONE
            && m_tuser != KIND_OUTSIDE && m_tuser != KIND_SYNC))
        else $error("packet end flagged on an aborted or outside item");

    // an aborted byte is reported as outside with no packet fields
    a_error_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[38:37] != ERR_NONE) |-> (m_tuser == KIND_OUTSIDE
            && m_tdata[18:8] == 11'd0 && !m_tlast))
        else $error("error item carries packet role or position");

    // only the check byte of a sum-checked packet carries a check result
    a_check_role: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[36:35] != CHK_NONE) |-> (m_tuser == KIND_CHECK
            && m_tdata[32:30] == EDM_SUM8))
        else $error("check status on a byte that is not a mode 2 check byte");
`endif

endmodule

`default_nettype wire
